// ===== rtl/cvst_pkg.sv =====
// Package for the controller value soft takeover block: types, codes and constants.
package cvst_pkg;

  localparam int unsigned ValW   = 17;
  localparam int unsigned StepsW = 31;
  localparam int unsigned CcW    = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DefNumSlots = 64;
  localparam int unsigned SlotInW = 6;
  localparam int unsigned DivW = 34;

  localparam logic [ValW-1:0] Unit = 17'd65536;

  localparam logic [ValW-1:0] PickupReset = 17'd3277;
  localparam logic [ValW-1:0] EdgeHighReset = 17'd64881;
  localparam logic [ValW-1:0] EdgeLowReset = 17'd655;

  localparam logic [CfgIdxW-1:0] CfgPickup   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEdgeHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgEdgeLow  = 2'd2;

  typedef enum logic [1:0] {
    ModeAbs   = 2'd0,
    ModeThree = 2'd1,
    ModeRel   = 2'd2,
    ModeNote  = 2'd3
  } mode_e;

  localparam logic [1:0] PhWait  = 2'd0;
  localparam logic [1:0] PhScale = 2'd1;
  localparam logic [1:0] PhLatch = 2'd2;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StEval,
    StDiv,
    StDone
  } state_e;

  // Control between the sequencer and the divider.
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] num;
    logic [DivW-1:0] den;
  } div_req_t;

endpackage

// ===== rtl/cvst_div.sv =====
// Restoring divider with rounding to nearest, one quotient bit per cycle.
module cvst_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cvst_pkg::div_req_t req_i,
  output logic              done_o,
  output logic [cvst_pkg::DivW-1:0] quo_o
);
  import cvst_pkg::*;

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0] num_q, num_d, den_q, den_d, quo_q, quo_d;
  logic [DivW:0]   rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DivW:0]   trial;

  always_comb begin
    num_d = num_q;
    den_d = den_q;
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = '0;
    if (req_i.start) begin
      // The rounding half is folded into the numerator up front.
      num_d = req_i.num + (req_i.den >> 1);
      den_d = req_i.den;
      quo_d = '0;
      rem_d = '0;
      cnt_d = CntW'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q[DivW-1:0], num_q[DivW-1]};
      num_d = {num_q[DivW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o = quo_q;

endmodule

// ===== rtl/controller_value_soft_takeover.sv =====
// Top level: controller value mapper with per-slot soft takeover state in memory.
//
// Channel   Direction  Handshake              Payload
// input     in         start_i, busy_o        func_i slot_i value_mode_i cc_value_i
//                                             param_value_i param_steps_i
// result    out        strobe_o               val_vld_o out_value_o
// config    in         cfg_we_i               cfg_idx_i cfg_data_i
//
// An item passes StIdle, StRead and StDone when no slot entry is evaluated;
// an absolute value that updates the slot's takeover entry adds StEval, a
// relative step adds StDiv and proportional travel adds StEval and StDiv; in
// StDiv the bit-serial divider works out 34 quotient bits. Reset returns
// every slot to waiting by clearing its valid bit; no clearing pass is needed.
// The result shows for one cycle on strobe_o and cannot be stalled; busy_o is
// high from acceptance until the strobe.
module controller_value_soft_takeover #(
  parameter int unsigned NumSlots = cvst_pkg::DefNumSlots
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             func_i,
  input  logic [cvst_pkg::SlotInW-1:0]     slot_i,
  input  logic [1:0]                       value_mode_i,
  input  logic [cvst_pkg::CcW-1:0]         cc_value_i,
  input  logic [cvst_pkg::ValW-1:0]        param_value_i,
  input  logic [cvst_pkg::StepsW-1:0]      param_steps_i,
  output logic                             strobe_o,
  output logic                             val_vld_o,
  output logic [cvst_pkg::ValW-1:0]        out_value_o,
  input  logic                             cfg_we_i,
  input  logic [cvst_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [cvst_pkg::ValW-1:0]        cfg_data_i
);
  import cvst_pkg::*;

  localparam int unsigned IdxW = (NumSlots > 1) ? $clog2(NumSlots) : 1;

  // Entry: phase, hw touch, sw touch.
  localparam int unsigned EntW = 2 + 2 * ValW;

  // Sub-step of the division chain.
  localparam logic [1:0] DStepTravel = 2'd1;
  localparam logic [1:0] DStepRel    = 2'd2;

  logic [ValW-1:0] pickup_q, edge_hi_q, edge_lo_q;

  state_e state_q, state_d;
  logic func_q;
  logic [IdxW-1:0] idx_q;
  mode_e mode_q;
  logic [CcW-1:0] cc_q;
  logic [ValW-1:0] pv_q;
  logic [StepsW-1:0] steps_q;

  logic [EntW-1:0] mem [NumSlots];
  logic [EntW-1:0] rd_q;
  logic [NumSlots-1:0] vld_q;
  logic vld_rd_q;
  logic we;
  logic [EntW-1:0] wdata;

  logic [1:0] dstep_q, dstep_d;
  logic [ValW-1:0] inc_q, inc_d;
  logic [ValW-1:0] s_q, s_d, h_q, h_d;
  logic up_q, up_d;
  logic has_q, has_d;
  logic [ValW-1:0] val_q, val_d;
  logic strobe_q, strobe_d;

  div_req_t req;
  logic div_done;
  logic [DivW-1:0] quo;

  logic [IdxW-1:0] slot_idx;
  logic [1:0] ph;
  logic [ValW-1:0] mem_h, mem_s;
  logic [ValW:0] sum;
  logic [ValW-1:0] d_in, t17;
  logic [StepsW-1:0] dd;

  function automatic logic [ValW-1:0] absdiff(input logic [ValW-1:0] a, input logic [ValW-1:0] b);
    absdiff = (a > b) ? a - b : b - a;
  endfunction

  // Slot wrap as a constant table over every possible slot code.
  function automatic logic [IdxW-1:0] wrap_slot(input logic [SlotInW-1:0] s);
    wrap_slot = '0;
    for (int i = 0; i < (1 << SlotInW); i++) begin
      if (s == SlotInW'(i)) wrap_slot = IdxW'(i % NumSlots);
    end
  endfunction

  // Absolute value (cc * 1.0 + 63) / 127, rounded, as a constant table.
  function automatic logic [ValW-1:0] abs_scale(input logic [CcW-1:0] cc);
    abs_scale = '0;
    for (int i = 0; i < (1 << CcW); i++) begin
      if (cc == CcW'(i)) abs_scale = ValW'((i * int'(Unit) + 63) / 127);
    end
  endfunction

  assign slot_idx = wrap_slot(slot_i);

  cvst_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .done_o(div_done),
    .quo_o (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pickup_q <= PickupReset;
      edge_hi_q <= EdgeHighReset;
      edge_lo_q <= EdgeLowReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPickup:   pickup_q <= cfg_data_i;
        CfgEdgeHigh: edge_hi_q <= cfg_data_i;
        CfgEdgeLow:  edge_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == StIdle) begin
      func_q <= func_i;
      idx_q <= slot_idx;
      mode_q <= mode_e'(value_mode_i);
      cc_q <= cc_value_i;
      pv_q <= (param_value_i > Unit) ? Unit : param_value_i;
      steps_q <= param_steps_i;
    end
  end

  // Slot memory: read in StRead, data available in StEval.
  always_ff @(posedge clk_i) begin
    if (we) mem[idx_q] <= wdata;
    rd_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (we) vld_q[idx_q] <= 1'b1;
      vld_rd_q <= vld_q[idx_q];
    end
  end

  assign ph = vld_rd_q ? rd_q[EntW-1 -: 2] : PhWait;
  assign mem_h = rd_q[2*ValW-1 -: ValW];
  assign mem_s = rd_q[ValW-1:0];

  always_comb begin
    state_d = state_q;
    dstep_d = dstep_q;
    inc_d = inc_q;
    s_d = s_q;
    h_d = h_q;
    up_d = up_q;
    has_d = has_q;
    val_d = val_q;
    strobe_d = 1'b0;
    req = '0;
    we = 1'b0;
    wdata = rd_q;
    sum = '0;
    t17 = '0;
    d_in = '0;
    dd = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) state_d = StRead;
      end
      StRead: begin
        has_d = 1'b0;
        val_d = '0;
        state_d = StDone;
        if (func_q) begin
          we = 1'b1;
          // Rearm writes the whole entry: phase waiting, touch values cleared.
          wdata = {PhWait, {2*ValW{1'b0}}};
        end else begin
          unique case (mode_q)
            ModeAbs: begin
              inc_d = abs_scale(cc_q);
              has_d = 1'b1;
              val_d = abs_scale(cc_q);
              if (steps_q > 31'd3) state_d = StEval;
            end
            ModeThree: begin
              has_d = 1'b1;
              val_d = (cc_q <= 7'd42) ? '0 : ((cc_q <= 7'd85) ? (Unit >> 1) : Unit);
            end
            ModeRel: begin
              if (cc_q != 7'd64) begin
                dd = ((steps_q < 31'd2) ? 31'd2 : steps_q) - 31'd1;
                req.start = 1'b1;
                req.num = DivW'(Unit);
                req.den = DivW'(dd);
                dstep_d = DStepRel;
                state_d = StDiv;
              end
            end
            default: ;
          endcase
        end
      end
      StEval: begin
        // Takeover update with the slot entry just read.
        state_d = StDone;
        has_d = 1'b1;
        val_d = inc_q;
        if (ph == PhWait) begin
          we = 1'b1;
          if (absdiff(inc_q, pv_q) < pickup_q) begin
            wdata = {PhLatch, inc_q, pv_q};
          end else begin
            wdata = {PhScale, inc_q, pv_q};
            h_d = inc_q;
            s_d = pv_q;
            if (inc_q >= edge_hi_q || inc_q <= edge_lo_q) begin
              wdata = {PhLatch, inc_q, pv_q};
            end else begin
              val_d = pv_q;
            end
          end
        end else if (ph == PhScale) begin
          h_d = mem_h;
          s_d = mem_s;
          if (inc_q >= edge_hi_q || inc_q <= edge_lo_q || absdiff(inc_q, mem_s) < pickup_q) begin
            we = 1'b1;
            wdata = {PhLatch, mem_h, mem_s};
          end else if (inc_q > mem_h) begin
            if (mem_h == Unit) begin
              val_d = mem_s;
            end else begin
              up_d = 1'b1;
              req.start = 1'b1;
              req.num = DivW'(inc_q - mem_h) * DivW'(Unit - mem_s);
              req.den = DivW'(Unit - mem_h);
              dstep_d = DStepTravel;
              state_d = StDiv;
            end
          end else if (inc_q < mem_h) begin
            up_d = 1'b0;
            req.start = 1'b1;
            req.num = DivW'(mem_h - inc_q) * DivW'(mem_s);
            req.den = DivW'(mem_h);
            dstep_d = DStepTravel;
            state_d = StDiv;
          end else begin
            val_d = mem_s;
          end
        end
      end
      StDiv: begin
        if (div_done) begin
          state_d = StDone;
          case (dstep_q)
            DStepTravel: begin
              has_d = 1'b1;
              if (up_q) begin
                sum = {1'b0, s_q} + quo[ValW:0];
                val_d = (sum > {1'b0, Unit}) ? Unit : sum[ValW-1:0];
              end else begin
                t17 = quo[ValW-1:0];
                val_d = (quo > DivW'(s_q)) ? '0 : s_q - t17;
              end
            end
            default: begin
              d_in = (quo > DivW'(Unit)) ? Unit : quo[ValW-1:0];
              if (cc_q > 7'd64) begin
                sum = {1'b0, pv_q} + {1'b0, d_in};
                val_d = (sum > {1'b0, Unit}) ? Unit : sum[ValW-1:0];
              end else begin
                val_d = (d_in > pv_q) ? '0 : pv_q - d_in;
              end
              has_d = (val_d != pv_q);
              if (!has_d) val_d = '0;
            end
          endcase
        end
      end
      StDone: begin
        strobe_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      strobe_q <= 1'b0;
      has_q <= 1'b0;
    end else begin
      state_q <= state_d;
      strobe_q <= strobe_d;
      has_q <= has_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dstep_q <= dstep_d;
    inc_q <= inc_d;
    s_q <= s_d;
    h_q <= h_d;
    up_q <= up_d;
    val_q <= val_d;
  end

  assign busy_o = (state_q != StIdle);
  assign strobe_o = strobe_q;
  assign val_vld_o = strobe_q & has_q;
  assign out_value_o = (strobe_q && has_q) ? val_q : '0;

  // The strobe follows only the final state.
  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(state_q) == StDone) else $error("strobe without done");
  a_idle_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !busy_o) else $error("busy after strobe");
  a_val_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> out_value_o <= Unit) else $error("value above one");

endmodule

// ===== tb/controller_value_soft_takeover_tb.sv =====
// Testbench for the controller value soft takeover block: random and directed items checked against a predictor.
`timescale 1ns / 1ps

module controller_value_soft_takeover_tb;
  import cvst_pkg::*;

  localparam int unsigned NSlots = 64;
  localparam int unsigned UnitI = 65536;

  typedef struct packed {
    logic               func;
    logic [SlotInW-1:0] slot;
    logic [1:0]         mode;
    logic [CcW-1:0]     cc;
    logic [ValW-1:0]    pv;
    logic [StepsW-1:0]  steps;
  } cmd_t;

  typedef struct packed {
    logic            has;
    logic [ValW-1:0] val;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic func_i = 1'b0;
  logic [SlotInW-1:0] slot_i = '0;
  logic [1:0] value_mode_i = '0;
  logic [CcW-1:0] cc_value_i = '0;
  logic [ValW-1:0] param_value_i = '0;
  logic [StepsW-1:0] param_steps_i = '0;
  logic strobe_o;
  logic val_vld_o;
  logic [ValW-1:0] out_value_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [ValW-1:0] cfg_data_i = '0;

  controller_value_soft_takeover u_dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Predictor copy of configuration and per-slot takeover state.
  logic [ValW-1:0] win_q, hi_q, lo_q;
  logic [1:0] phase_q [NSlots];
  logic [ValW-1:0] hw_q [NSlots];
  logic [ValW-1:0] sw_q [NSlots];

  cmd_t pending_cmds[$];
  res_t expected_res[$];
  int unsigned errors = 0;
  int unsigned idle_pct = 36;

  function automatic longint unsigned rdiv(longint unsigned n, longint unsigned d);
    return (n + d / 2) / d;
  endfunction

  function automatic longint unsigned adiff(longint unsigned a, longint unsigned b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic res_t map_item(cmd_t c);
    res_t r;
    longint unsigned pv, v, d, st, nx, h, s, den, o, t;
    int unsigned ix;
    r = '0;
    ix = c.slot % NSlots;
    pv = c.pv > UnitI ? UnitI : c.pv;
    if (c.func) begin
      phase_q[ix] = PhWait;
    end else if (c.mode == ModeAbs) begin
      v = (c.cc * UnitI + 63) / 127;
      if (c.steps > 3) begin
        if (phase_q[ix] == PhWait) begin
          hw_q[ix] = ValW'(v);
          sw_q[ix] = ValW'(pv);
          phase_q[ix] = adiff(v, pv) < win_q ? PhLatch : PhScale;
        end
        if (phase_q[ix] == PhScale) begin
          h = hw_q[ix];
          s = sw_q[ix];
          if (v >= hi_q || v <= lo_q || adiff(v, s) < win_q) begin
            phase_q[ix] = PhLatch;
          end else if (v > h) begin
            den = UnitI > h ? UnitI - h : 0;
            if (den == 0 || s > UnitI) v = s;
            else begin
              o = s + rdiv((v - h) * (UnitI - s), den);
              v = o > UnitI ? UnitI : o;
            end
          end else if (v < h) begin
            t = rdiv((h - v) * s, h);
            v = t > s ? 0 : s - t;
          end else begin
            v = s;
          end
        end
      end
      r.has = 1'b1;
      r.val = ValW'(v);
    end else if (c.mode == ModeThree) begin
      r.has = 1'b1;
      r.val = ValW'(c.cc <= 42 ? 0 : (c.cc <= 85 ? UnitI / 2 : UnitI));
    end else if (c.mode == ModeRel && c.cc != 64) begin
      d = (c.steps < 2 ? 2 : c.steps) - 1;
      st = rdiv(UnitI, d);
      if (c.cc > 64) nx = pv + st > UnitI ? UnitI : pv + st;
      else nx = st > pv ? 0 : pv - st;
      if (nx != pv) begin
        r.has = 1'b1;
        r.val = ValW'(nx);
      end
    end
    return r;
  endfunction

  // Driver: presents queued items at the falling edge, with random gaps.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (pending_cmds.size() > 0 && !busy_o && ($urandom_range(99) >= idle_pct)) begin
        cmd_t c;
        c = pending_cmds.pop_front();
        func_i <= c.func;
        slot_i <= c.slot;
        value_mode_i <= c.mode;
        cc_value_i <= c.cc;
        param_value_i <= c.pv;
        param_steps_i <= c.steps;
        start_i <= 1'b1;
        expected_res.insert(expected_res.size(), map_item(c));
      end else if (!(start_i && busy_o)) begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: every strobe is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result has=%0b val=%0d", $time, val_vld_o, out_value_o);
        errors++;
      end else begin
        res_t e;
        e = expected_res.pop_front();
        if (e.has !== val_vld_o) begin
          $display("%0t: val_vld expected %0b actual %0b", $time, e.has, val_vld_o);
          errors++;
        end
        if (e.val !== out_value_o) begin
          $display("%0t: out_value expected %0d actual %0d", $time, e.val, out_value_o);
          errors++;
        end
      end
    end
  end

  task automatic queue_cmd(input cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ValW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgPickup) win_q = data;
    else if (idx == CfgEdgeHigh) hi_q = data;
    else lo_q = data;
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || start_i || busy_o || expected_res.size() > 0)
      @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c.func = ($urandom_range(9) == 0);
    c.slot = SlotInW'($urandom_range(7));
    if ($urandom_range(9) == 0) c.slot = SlotInW'($urandom);
    c.mode = ($urandom_range(1) == 0) ? ModeAbs : 2'($urandom_range(3));
    c.cc = CcW'($urandom);
    case ($urandom_range(4))
      0: c.pv = ValW'($urandom_range(UnitI + 3, UnitI - 3));
      1: c.pv = ValW'($urandom);
      default: c.pv = ValW'($urandom_range(UnitI));
    endcase
    case ($urandom_range(5))
      0: c.steps = StepsW'($urandom_range(4));
      1: c.steps = StepsW'($urandom);
      2: c.steps = {31{1'b1}};
      default: c.steps = StepsW'($urandom_range(200, 4));
    endcase
    return c;
  endfunction

  function automatic cmd_t mk(logic f, logic [5:0] sl, logic [1:0] m, logic [6:0] cc,
                              logic [16:0] pv, logic [30:0] st);
    cmd_t c;
    c.func = f; c.slot = sl; c.mode = m; c.cc = cc; c.pv = pv; c.steps = st;
    return c;
  endfunction

  initial begin
    win_q = PickupReset;
    hi_q = EdgeHighReset;
    lo_q = EdgeLowReset;
    for (int i = 0; i < NSlots; i++) begin
      phase_q[i] = PhWait;
      hw_q[i] = '0;
      sw_q[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: modes, extremes, saturation, rearm and scaling paths.
    queue_cmd(mk(0, 0, ModeAbs, 0, 0, 0));
    queue_cmd(mk(0, 0, ModeAbs, 127, 17'h1FFFF, 3));
    queue_cmd(mk(0, 1, ModeThree, 42, 0, 5));
    queue_cmd(mk(0, 1, ModeThree, 43, 0, 5));
    queue_cmd(mk(0, 1, ModeThree, 86, 0, 5));
    queue_cmd(mk(0, 2, ModeRel, 64, 100, 10));
    queue_cmd(mk(0, 2, ModeRel, 65, 65536, 10));
    queue_cmd(mk(0, 2, ModeRel, 63, 0, 0));
    queue_cmd(mk(0, 2, ModeRel, 65, 1000, 31'h7FFFFFFF));
    queue_cmd(mk(0, 2, ModeRel, 1, 17'h1FFFF, 1));
    queue_cmd(mk(0, 3, ModeNote, 127, 17'h1FFFF, 31'h7FFFFFFF));
    queue_cmd(mk(0, 4, ModeAbs, 20, 50000, 100));
    queue_cmd(mk(0, 4, ModeAbs, 40, 50000, 100));
    queue_cmd(mk(0, 4, ModeAbs, 10, 50000, 100));
    queue_cmd(mk(0, 4, ModeAbs, 20, 50000, 100));
    queue_cmd(mk(0, 4, ModeAbs, 127, 50000, 100));
    queue_cmd(mk(1, 4, ModeAbs, 0, 0, 0));
    queue_cmd(mk(0, 4, ModeAbs, 100, 10000, 100));
    queue_cmd(mk(0, 4, ModeAbs, 110, 10000, 100));
    queue_cmd(mk(0, 4, ModeAbs, 0, 10000, 100));
    queue_cmd(mk(0, 63, ModeAbs, 127, 0, 4));
    queue_cmd(mk(0, 63, ModeAbs, 126, 0, 4));
    queue_cmd(mk(1, 63, ModeNote, 127, 17'h1FFFF, 31'h7FFFFFFF));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin write_reg(CfgPickup, 0); write_reg(CfgEdgeHigh, 17'h1FFFF);
                 write_reg(CfgEdgeLow, 0); end
        2: begin write_reg(CfgPickup, 65536); write_reg(CfgEdgeHigh, 0);
                 write_reg(CfgEdgeLow, 65536); end
        3: begin write_reg(CfgPickup, 500); write_reg(CfgEdgeHigh, 65536);
                 write_reg(CfgEdgeLow, 17'h1FFFF); write_reg(CfgEdgeLow, 100); end
        4: begin write_reg(CfgPickup, ValW'($urandom)); write_reg(CfgEdgeHigh, ValW'($urandom));
                 write_reg(CfgEdgeLow, ValW'($urandom_range(2000))); end
        default: ;
      endcase
      // Rearm slots 0 to 7, which most items use, so each phase starts them from first touch.
      for (int s = 0; s < 8; s++) queue_cmd(mk(1, 6'(s), ModeAbs, 0, 0, 0));
      idle_pct = (ph == 2) ? 0 : 36;
      for (int i = 0; i < 250; i++) queue_cmd(rand_cmd());
      drain();
    end

    if (errors == 0) begin
      $display("controller_value_soft_takeover_tb: PASS");
    end else begin
      $display("controller_value_soft_takeover_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("controller_value_soft_takeover_tb: FAIL");
    $finish;
  end

endmodule
